// File: hdl/tcq_pkg.sv
// Shared types and constants for the three-class priority task queue.
package tcq_pkg;

    localparam int NUM_CLASSES       = 3;
    localparam int DEF_QUEUE_DEPTH   = 16;
    localparam int DEF_ID_WIDTH      = 16;
    localparam int EXT_ID_WIDTH      = 16;

    typedef enum logic [1:0] {
        OP_SUBMIT = 2'd0,
        OP_CANCEL = 2'd1,
        OP_POP    = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2,
        ST_DUP  = 2'd3
    } status_t;

    localparam logic [1:0] CLASS_NONE = 2'd3;
    localparam logic [1:0] CLASS_LAST = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_CMP,
        S_SHRD,
        S_SHWR,
        S_FIN
    } state_t;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } ram_ctl_t;

endpackage

// File: hdl/tcq_ram.sv
// Entry store: one write port, one read port with registered read data.
module tcq_ram
    import tcq_pkg::*;
#(
    parameter int DEPTH = 3 * DEF_QUEUE_DEPTH,
    parameter int DW    = DEF_ID_WIDTH + 1,
    localparam int AW   = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  ram_ctl_t      ctl,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/three_class_priority_task_queue.sv
// Top level: sequencer, queue counts and result register around the entry store.
//
//   channel | handshake          | fields
//   --------+--------------------+--------------------------------------
//   input   | in_valid, in_stall | op, queue_class, task_id, is_high
//   output  | out_valid,out_stall| status, out_id, out_high
//
// Every entry visited takes a memory read and then a compare or a write back, since
// the single read port has registered read data. A submit scans every held entry of
// all three queues unless it meets a duplicate; a cancel scans at most as many. A pop
// scans its class for the first high-priority entry and takes it, or takes the head
// when there is none, and then shifts the later entries of that class down; an empty
// pop or unknown op goes straight to its result.
// Reset clears the three counts at once; the store needs no clearing pass.
// A new transaction is taken whenever the sequencer is idle, even while a result
// waits in the output register; the sequencer only waits if it has a second result.
module three_class_priority_task_queue
    import tcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = DEF_ID_WIDTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  op,
    input  logic [1:0]  queue_class,
    input  logic [15:0] task_id,
    input  logic        is_high,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] out_id,
    output logic        out_high
);

    localparam int SLOTS = NUM_CLASSES * QUEUE_DEPTH;
    localparam int AW    = $clog2(SLOTS);
    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int DW    = ID_WIDTH + 1;
    localparam int KW    = (ID_WIDTH < EXT_ID_WIDTH) ? ID_WIDTH : EXT_ID_WIDTH;

    function automatic logic [AW-1:0] slot_addr(logic [1:0] c, logic [CW-1:0] p);
        return AW'(c) * AW'(QUEUE_DEPTH) + AW'(p);
    endfunction

    function automatic logic [EXT_ID_WIDTH-1:0] ext_id(logic [ID_WIDTH-1:0] v);
        logic [EXT_ID_WIDTH-1:0] r;
        r = '0;
        r[KW-1:0] = v[KW-1:0];
        return r;
    endfunction

    state_t                  state_reg, state_next;
    op_t                     op_reg, op_next;
    logic [1:0]              cls_reg, cls_next;
    logic [1:0]              cur_cls_reg, cur_cls_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [ID_WIDTH-1:0]     key_reg, key_next;
    logic                    high_reg, high_next;
    logic [CW-1:0]           cnt_reg [NUM_CLASSES];
    logic [CW-1:0]           cnt_next [NUM_CLASSES];
    status_t                 res_status_reg, res_status_next;
    logic [EXT_ID_WIDTH-1:0] res_id_reg, res_id_next;
    logic                    res_high_reg, res_high_next;
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [EXT_ID_WIDTH-1:0] out_id_reg, out_id_next;
    logic                    out_high_reg, out_high_next;

    ram_ctl_t                ram_ctl;
    logic [AW-1:0]           ram_waddr, ram_raddr;
    logic [DW-1:0]           ram_wdata, ram_rdata;

    logic [ID_WIDTH-1:0]     in_id;
    logic [CW-1:0]           in_cnt, cls_cnt, cur_cnt, pos_inc;
    logic [ID_WIDTH-1:0]     rd_id;
    logic                    rd_high;

    tcq_ram #(
        .DEPTH (SLOTS),
        .DW    (DW)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        in_id = '0;
        in_id[KW-1:0] = task_id[KW-1:0];
    end

    // Class three has no queue and reads as an empty one.
    always_comb
    begin
        in_cnt  = '0;
        cls_cnt = '0;
        cur_cnt = '0;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            if (queue_class == 2'(c))
            begin
                in_cnt = cnt_reg[c];
            end
            if (cls_reg == 2'(c))
            begin
                cls_cnt = cnt_reg[c];
            end
            if (cur_cls_reg == 2'(c))
            begin
                cur_cnt = cnt_reg[c];
            end
        end
    end

    assign pos_inc = pos_reg + CW'(1);
    assign rd_id   = ram_rdata[ID_WIDTH-1:0];
    assign rd_high = ram_rdata[ID_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            for (int c = 0; c < NUM_CLASSES; c++)
            begin
                cnt_reg[c] <= cnt_next[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        cls_reg        <= cls_next;
        cur_cls_reg    <= cur_cls_next;
        pos_reg        <= pos_next;
        key_reg        <= key_next;
        high_reg       <= high_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_high_reg   <= res_high_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_high_reg   <= out_high_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        cls_next        = cls_reg;
        cur_cls_next    = cur_cls_reg;
        pos_next        = pos_reg;
        key_next        = key_reg;
        high_next       = high_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_high_next   = res_high_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_high_next   = out_high_reg;
        for (int c = 0; c < NUM_CLASSES; c++)
        begin
            cnt_next[c] = cnt_reg[c];
        end
        ram_ctl   = '0;
        ram_waddr = '0;
        ram_wdata = '0;
        ram_raddr = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next         = op_t'(op);
                    cls_next        = queue_class;
                    key_next        = in_id;
                    high_next       = is_high;
                    pos_next        = '0;
                    cur_cls_next    = '0;
                    res_id_next     = ext_id(in_id);
                    res_high_next   = 1'b0;
                    res_status_next = ST_MISS;
                    case (op_t'(op))
                        OP_SUBMIT, OP_CANCEL:
                        begin
                            state_next = S_RD;
                        end
                        OP_POP:
                        begin
                            res_id_next = '0;
                            if (queue_class == CLASS_NONE || in_cnt == '0)
                            begin
                                state_next = S_FIN;
                            end
                            else
                            begin
                                cur_cls_next = queue_class;
                                state_next   = S_RD;
                            end
                        end
                        default:
                        begin
                            res_id_next = '0;
                            state_next  = S_FIN;
                        end
                    endcase
                end
            end

            S_RD:
            begin
                if (pos_reg < cur_cnt)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_raddr     = slot_addr(cur_cls_reg, pos_reg);
                    state_next    = S_CMP;
                end
                else if (op_reg == OP_POP)
                begin
                    // No high-priority entry: the head, kept from the first compare, goes.
                    pos_next   = '0;
                    state_next = S_SHRD;
                end
                else if (cur_cls_reg != CLASS_LAST)
                begin
                    cur_cls_next = cur_cls_reg + 2'd1;
                    pos_next     = '0;
                end
                else if (op_reg == OP_CANCEL)
                begin
                    res_status_next = ST_MISS;
                    state_next      = S_FIN;
                end
                else
                begin
                    if (cls_reg == CLASS_NONE)
                    begin
                        res_status_next = ST_MISS;
                    end
                    else if (cls_cnt == CW'(QUEUE_DEPTH))
                    begin
                        res_status_next = ST_FULL;
                    end
                    else
                    begin
                        ram_ctl.wr_en   = 1'b1;
                        ram_waddr       = slot_addr(cls_reg, cls_cnt);
                        ram_wdata       = {high_reg, key_reg};
                        res_status_next = ST_OK;
                        for (int c = 0; c < NUM_CLASSES; c++)
                        begin
                            if (cls_reg == 2'(c))
                            begin
                                cnt_next[c] = cnt_reg[c] + CW'(1);
                            end
                        end
                    end
                    state_next = S_FIN;
                end
            end

            S_CMP:
            begin
                if (op_reg == OP_POP)
                begin
                    if (pos_reg == '0 || rd_high)
                    begin
                        res_id_next   = ext_id(rd_id);
                        res_high_next = rd_high;
                    end
                    if (rd_high)
                    begin
                        state_next = S_SHRD;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = S_RD;
                    end
                end
                else if (rd_id == key_reg)
                begin
                    if (op_reg == OP_SUBMIT)
                    begin
                        res_status_next = ST_DUP;
                        state_next      = S_FIN;
                    end
                    else
                    begin
                        state_next = S_SHRD;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_RD;
                end
            end

            S_SHRD:
            begin
                if (pos_inc < cur_cnt)
                begin
                    ram_ctl.rd_en = 1'b1;
                    ram_raddr     = slot_addr(cur_cls_reg, pos_inc);
                    state_next    = S_SHWR;
                end
                else
                begin
                    for (int c = 0; c < NUM_CLASSES; c++)
                    begin
                        if (cur_cls_reg == 2'(c))
                        begin
                            cnt_next[c] = cnt_reg[c] - CW'(1);
                        end
                    end
                    res_status_next = ST_OK;
                    state_next      = S_FIN;
                end
            end

            S_SHWR:
            begin
                ram_ctl.wr_en = 1'b1;
                ram_waddr     = slot_addr(cur_cls_reg, pos_reg);
                ram_wdata     = ram_rdata;
                pos_next      = pos_inc;
                state_next    = S_SHRD;
            end

            S_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_id_next     = res_id_reg;
                    out_high_next   = res_high_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign out_id    = out_id_reg;
    assign out_high  = out_high_reg;

    // The store is never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_ctl.wr_en && ram_ctl.rd_en))
        else $error("entry store read and written in one cycle");

    // Writes stay inside the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_ctl.wr_en |-> (ram_waddr < AW'(SLOTS)))
        else $error("entry store write out of range");

    // A compare only ever sees an entry below its queue's count.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (cur_cls_reg != CLASS_NONE && pos_reg < cur_cnt))
        else $error("compare of an entry that is not held");

    // No queue grows beyond its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[0] <= CW'(QUEUE_DEPTH) && cnt_reg[1] <= CW'(QUEUE_DEPTH)
        && cnt_reg[2] <= CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the three-class priority task queue.
`timescale 1ns / 100ps

module testbench;
    import tcq_pkg::*;

    localparam int DEPTH       = DEF_QUEUE_DEPTH;
    localparam int CYCLE_LIMIT = 800000;
    localparam int HOLD_AFTER  = 300;
    localparam int HOLD_CYCLES = 400;
    localparam int RANDOM_ITEMS = 1300;

    typedef struct packed {
        logic [15:0] id;
        logic        high;
    } task_entry_t;

    typedef struct packed {
        op_t         op;
        logic [1:0]  cls;
        logic [15:0] id;
        logic        high;
    } task_req_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] id;
        logic        high;
    } task_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  op = OP_NONE;
    logic [1:0]  queue_class = 2'd0;
    logic [15:0] task_id = 16'd0;
    logic        is_high = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] out_id;
    logic        out_high;

    task_req_t    pending_requests[$];
    task_result_t expected_results[$];
    task_entry_t  held_tasks[NUM_CLASSES][$];
    logic [15:0]  id_pool[128];

    int  mismatches = 0;
    int  tasks_taken = 0;
    int  cycle_no = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_cycles = 0;
    bit  hold_done = 1'b0;
    logic hold_off = 1'b0;

    three_class_priority_task_queue u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .queue_class (queue_class),
        .task_id     (task_id),
        .is_high     (is_high),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_id      (out_id),
        .out_high    (out_high)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("%0t mismatch: %s", $time, msg);
    endtask

    // Mostly short pauses, now and then a long one.
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    function automatic bit find_held_task(input logic [15:0] id, output int cls,
                                          output int pos);
        for (int c = 0; c < NUM_CLASSES; c++) begin
            for (int i = 0; i < held_tasks[c].size(); i++) begin
                if (held_tasks[c][i].id == id) begin
                    cls = c;
                    pos = i;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one transaction to the shadow queues and returns the answer it must give.
    function automatic task_result_t predict_outcome(input task_req_t rq);
        task_result_t r;
        task_entry_t  e;
        int           fc;
        int           fp;
        bit           found;
        r.status = ST_MISS;
        r.id     = '0;
        r.high   = 1'b0;
        fc       = 0;
        fp       = 0;
        found    = find_held_task(rq.id, fc, fp);
        case (rq.op)
            OP_SUBMIT: begin
                r.id = rq.id;
                if (found) begin
                    r.status = ST_DUP;
                end
                else if (rq.cls != CLASS_NONE) begin
                    if (held_tasks[rq.cls].size() >= DEPTH) begin
                        r.status = ST_FULL;
                    end
                    else begin
                        e.id   = rq.id;
                        e.high = rq.high;
                        held_tasks[rq.cls].insert(held_tasks[rq.cls].size(), e);
                        r.status = ST_OK;
                    end
                end
            end
            OP_CANCEL: begin
                r.id = rq.id;
                if (found) begin
                    held_tasks[fc].delete(fp);
                    r.status = ST_OK;
                end
            end
            OP_POP: begin
                if (rq.cls != CLASS_NONE && held_tasks[rq.cls].size() > 0) begin
                    fp = 0;
                    for (int i = 0; i < held_tasks[rq.cls].size(); i++) begin
                        if (held_tasks[rq.cls][i].high) begin
                            fp = i;
                            break;
                        end
                    end
                    r.id     = held_tasks[rq.cls][fp].id;
                    r.high   = held_tasks[rq.cls][fp].high;
                    held_tasks[rq.cls].delete(fp);
                    r.status = ST_OK;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic queue_request(input op_t o, input logic [1:0] c, input logic [15:0] id,
                                 input logic h);
        task_req_t rq;
        rq.op   = o;
        rq.cls  = c;
        rq.id   = id;
        rq.high = h;
        pending_requests.insert(pending_requests.size(), rq);
    endtask

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 99) < 85)
            return id_pool[$urandom_range(0, 127)];
        return 16'($urandom);
    endfunction

    function automatic logic [1:0] pick_class();
        if ($urandom_range(0, 99) < 5)
            return CLASS_NONE;
        return 2'($urandom_range(0, CLASS_LAST));
    endfunction

    // Directed opening, then episodes that fill, drain or mix the queues.
    task automatic build_stimulus();
        int          kind;
        int          len;
        int          r;
        logic [1:0]  c;
        queue_request(OP_POP,    2'd0,       16'h0000, 1'b0);
        queue_request(OP_POP,    CLASS_NONE, 16'h0000, 1'b0);
        queue_request(OP_SUBMIT, CLASS_NONE, 16'h1234, 1'b1);
        queue_request(OP_NONE,   2'd2,       16'hFFFF, 1'b1);
        queue_request(OP_CANCEL, 2'd1,       16'hFFFF, 1'b0);
        queue_request(OP_SUBMIT, 2'd0,       16'h0000, 1'b0);
        queue_request(OP_SUBMIT, 2'd0,       16'hFFFF, 1'b1);
        queue_request(OP_SUBMIT, 2'd0,       16'hAAAA, 1'b0);
        queue_request(OP_SUBMIT, 2'd1,       16'h0000, 1'b1);
        queue_request(OP_SUBMIT, 2'd1,       16'h5555, 1'b1);
        queue_request(OP_SUBMIT, 2'd2,       16'h8001, 1'b0);
        queue_request(OP_POP,    2'd0,       16'h0000, 1'b0);
        queue_request(OP_SUBMIT, 2'd2,       16'hFFFF, 1'b0);
        queue_request(OP_POP,    2'd0,       16'h0000, 1'b1);
        queue_request(OP_CANCEL, 2'd0,       16'hAAAA, 1'b0);
        queue_request(OP_POP,    2'd0,       16'h0000, 1'b0);
        queue_request(OP_CANCEL, 2'd3,       16'hFFFF, 1'b1);
        queue_request(OP_POP,    2'd1,       16'h0000, 1'b0);
        queue_request(OP_POP,    2'd2,       16'h0000, 1'b0);
        queue_request(OP_POP,    2'd2,       16'h0000, 1'b0);
        foreach (id_pool[i])
            id_pool[i] = 16'($urandom);
        while (pending_requests.size() < RANDOM_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(8, 24);
            c    = 2'($urandom_range(0, CLASS_LAST));
            for (int k = 0; k < len; k++) begin
                r = $urandom_range(0, 99);
                if (kind < 4) begin
                    // A fill submits mostly to one class and can push it past full; the odd other operation mixes in.
                    if (r < 90)
                        queue_request(OP_SUBMIT, c, pick_id(), $urandom_range(0, 2) == 0);
                    else
                        queue_request(OP_POP, pick_class(), 16'($urandom), 1'($urandom));
                end
                else if (kind < 7) begin
                    if (r < 70)
                        queue_request(OP_POP, c, 16'($urandom), 1'($urandom));
                    else
                        queue_request(OP_CANCEL, 2'($urandom), pick_id(), 1'($urandom));
                end
                else begin
                    if (r < 40)
                        queue_request(OP_SUBMIT, pick_class(), pick_id(),
                                      $urandom_range(0, 2) == 0);
                    else if (r < 65)
                        queue_request(OP_CANCEL, 2'($urandom), pick_id(), 1'($urandom));
                    else if (r < 95)
                        queue_request(OP_POP, pick_class(), 16'($urandom), 1'($urandom));
                    else
                        queue_request(OP_NONE, 2'($urandom), 16'($urandom),
                                      1'($urandom));
                end
            end
        end
    endtask

    // Driver: predicts each transaction as it is taken and offers the next one.
    always @(posedge clk or negedge rst_n) begin : drive
        task_req_t rq;
        bit        taken;
        if (!rst_n) begin
            in_valid    <= 1'b0;
            op          <= OP_NONE;
            queue_class <= 2'd0;
            task_id     <= 16'd0;
            is_high     <= 1'b0;
        end
        else begin
            taken = in_valid && !in_stall;
            if (taken) begin
                rq.op   = op_t'(op);
                rq.cls  = queue_class;
                rq.id   = task_id;
                rq.high = is_high;
                expected_results.insert(expected_results.size(), predict_outcome(rq));
                tasks_taken++;
            end
            if (!in_valid || taken) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_requests.size() > 0) begin
                    rq = pending_requests.pop_front();
                    op          <= rq.op;
                    queue_class <= rq.cls;
                    task_id     <= rq.id;
                    is_high     <= rq.high;
                    in_valid    <= 1'b1;
                    gap_left = ((tasks_taken / 100) % 4 == 1) ? 0 : idle_length();
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // One long hold-off on the result side, so that the block backs up to its input.
    always @(posedge clk) begin
        if (hold_off) begin
            if (hold_cycles == 0)
                hold_off <= 1'b0;
            else
                hold_cycles--;
        end
        else if (!hold_done && tasks_taken >= HOLD_AFTER) begin
            hold_off    <= 1'b1;
            hold_cycles = HOLD_CYCLES;
            hold_done   = 1'b1;
        end
    end

    // Monitor: checks each result transaction against the oldest prediction.
    always @(posedge clk or negedge rst_n) begin : monitor
        task_result_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected: status %0d id %h",
                                              status, out_id));
                end
                else begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf("status %0d, want %0d", status,
                                                  want.status));
                    if (out_id !== want.id)
                        report_mismatch($sformatf("out_id %h, want %h", out_id, want.id));
                    if (out_high !== want.high)
                        report_mismatch($sformatf("out_high %b, want %b", out_high,
                                                  want.high));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if ((cycle_no / 1000) % 3 != 0 && $urandom_range(0, 3) == 0)
                stall_left = idle_length();
            out_stall <= hold_off || (stall_left > 0);
        end
    end

    always @(posedge clk) begin
        cycle_no++;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        build_stimulus();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_requests.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

// File: files.f
hdl/tcq_pkg.sv
hdl/tcq_ram.sv
hdl/three_class_priority_task_queue.sv
tb/testbench.sv
